### rtl/stereo_chorus_delay_macros.svh
// ---------------------------------------------------------------------------
// stereo chorus delay assertion macros
// shared concurrent check wrappers on the clock and reset of the block
// ---------------------------------------------------------------------------
`ifndef STEREO_CHORUS_DELAY_MACROS_SVH
`define STEREO_CHORUS_DELAY_MACROS_SVH

// check outside of reset
`define SCD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check on every edge, reset included
`define SCD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/scd_pkg.sv
// ---------------------------------------------------------------------------
// scd_pkg
// constants, types and the quarter sine table of the stereo chorus delay
// ---------------------------------------------------------------------------
`default_nettype none

package scd_pkg;

   localparam int LINE_DEPTH      = 4096;
   localparam int LINE_BITS       = $clog2(LINE_DEPTH);
   localparam int LFO_CHUNK       = 32;
   localparam int LFO_CHUNK_BITS  = $clog2(LFO_CHUNK);
   localparam int SINE_TABLE_BITS = 10;
   localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
   localparam int QUARTER_SIZE    = 1 << QUARTER_BITS;

   localparam int SAMPLE_W = 24;
   localparam int GAIN_W   = 17;
   localparam int CENTER_W = 20;
   localparam int PHASE_W  = 32;
   localparam int FRAC_W   = 16;
   localparam int POS_W    = LINE_BITS + FRAC_W;

   localparam logic [GAIN_W-1:0]  GAIN_ONE     = GAIN_W'(65536);
   localparam logic [PHASE_W-1:0] QUARTER_TURN = PHASE_W'(64'h4000_0000);
   localparam logic [POS_W-1:0]   DELAY_MIN    = POS_W'(64'd1 << FRAC_W);
   localparam logic [POS_W-1:0]   DELAY_MAX    = POS_W'(64'(LINE_DEPTH - 2) << FRAC_W);

   localparam logic signed [SAMPLE_W-1:0] S24_MAX = 24'sh7F_FFFF;
   localparam logic signed [SAMPLE_W-1:0] S24_MIN = 24'sh80_0000;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [22:0] qsine_type;
   typedef qsine_type qsine_table_type [0:QUARTER_SIZE];

   typedef enum logic [1:0] {
      CSR_WET_LEVEL,
      CSR_CENTER_DELAY,
      CSR_DEPTH,
      CSR_PHASE_STEP
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LFO,
      ST_WRITE,
      ST_DELAY,
      ST_POS,
      ST_RDA,
      ST_RDB,
      ST_MUL,
      ST_INTERP,
      ST_GAIN,
      ST_SUM,
      ST_OUT
   } top_state_type;

   typedef enum logic [2:0] {
      LFO_IDLE,
      LFO_RD_S0,
      LFO_RD_C0,
      LFO_RD_S1,
      LFO_RD_C1,
      LFO_WAIT,
      LFO_LOAD
   } lfo_state_type;

   typedef struct packed {
      logic refresh;
      logic advance;
   } lfo_ctrl_type;

   typedef struct packed {
      logic done;
      logic chunk_zero;
   } lfo_stat_type;

   typedef struct packed {
      logic write;
      logic delay;
      logic pos;
      logic rd_next;
      logic load_a;
      logic mul;
      logic interp;
      logic gain;
      logic sum;
   } lane_ctrl_type;

   function automatic qsine_table_type build_qsine();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      qsine_table_type t;
      for (int k = 0; k <= QUARTER_SIZE; k++) begin
         x    = (longint'(k) * HALF_PI_Q30) >> QUARTER_BITS;
         x2   = (x * x) >> 30;
         term = ((x * x2) >> 30) / 6;
         sum  = x - term;
         term = ((term * x2) >> 30) / 20;
         sum  = sum + term;
         term = ((term * x2) >> 30) / 42;
         sum  = sum - term;
         term = ((term * x2) >> 30) / 72;
         sum  = sum + term;
         term = ((term * x2) >> 30) / 110;
         sum  = sum - term;
         term = ((term * x2) >> 30) / 156;
         sum  = sum + term;
         sum  = (sum + 64) >> 7;
         if (sum > 64'd8388607) begin
            sum = 64'd8388607;
         end
         t[k] = sum[22:0];
      end
      return t;
   endfunction

   localparam qsine_table_type QSINE_TABLE = build_qsine();

endpackage

`default_nettype wire

### rtl/scd_lfo.sv
// ---------------------------------------------------------------------------
// scd_lfo
// phase accumulator lfo with sine table, chunk start lookup and linear steps
// ---------------------------------------------------------------------------
`default_nettype none

module scd_lfo (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [scd_pkg::PHASE_W-1:0]   phase_step,
   input  wire scd_pkg::lfo_ctrl_type         ctrl,
   output scd_pkg::lfo_stat_type              stat,
   output scd_pkg::sample_type                mod_sine,
   output scd_pkg::sample_type                mod_cosine
);

   scd_pkg::lfo_state_type state_ff, state_in;
   scd_pkg::lfo_state_type tag_ff;

   logic [scd_pkg::PHASE_W-1:0]        phase_ff;
   logic [scd_pkg::LFO_CHUNK_BITS-1:0] chunk_ff;
   scd_pkg::sample_type                msin_ff, mcos_ff, isin_ff, icos_ff;
   scd_pkg::sample_type                s0_ff, c0_ff, s1_ff, c1_ff;

   logic [scd_pkg::PHASE_W-1:0]         end_phase, rd_phase;
   logic [scd_pkg::SINE_TABLE_BITS-1:0] idx;
   logic [scd_pkg::QUARTER_BITS:0]      rom_addr;
   scd_pkg::qsine_type                  rom_ff;
   logic                                neg_ff;
   scd_pkg::sample_type                 rom_val;

   logic signed [scd_pkg::SAMPLE_W:0] dsin, dcos, asin, acos, nsin, ncos;

   assign end_phase = phase_ff + (phase_step << scd_pkg::LFO_CHUNK_BITS);

   always_comb begin
      case (state_ff)
         scd_pkg::LFO_RD_C0: rd_phase = phase_ff + scd_pkg::QUARTER_TURN;
         scd_pkg::LFO_RD_S1: rd_phase = end_phase;
         scd_pkg::LFO_RD_C1: rd_phase = end_phase + scd_pkg::QUARTER_TURN;
         default:            rd_phase = phase_ff;
      endcase
   end

   assign idx = rd_phase[scd_pkg::PHASE_W-1 -: scd_pkg::SINE_TABLE_BITS];

   always_comb begin
      if (idx[scd_pkg::QUARTER_BITS]) begin
         rom_addr = (scd_pkg::QUARTER_BITS+1)'(scd_pkg::QUARTER_SIZE)
                    - {1'b0, idx[scd_pkg::QUARTER_BITS-1:0]};
      end else begin
         rom_addr = {1'b0, idx[scd_pkg::QUARTER_BITS-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      rom_ff <= scd_pkg::QSINE_TABLE[rom_addr];
      neg_ff <= idx[scd_pkg::SINE_TABLE_BITS-1];
   end

   assign rom_val = neg_ff ? -$signed({1'b0, rom_ff}) : $signed({1'b0, rom_ff});

   always_ff @(posedge clock) begin
      case (tag_ff)
         scd_pkg::LFO_RD_S0: s0_ff <= rom_val;
         scd_pkg::LFO_RD_C0: c0_ff <= rom_val;
         scd_pkg::LFO_RD_S1: s1_ff <= rom_val;
         scd_pkg::LFO_RD_C1: c1_ff <= rom_val;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scd_pkg::LFO_IDLE;
         tag_ff   <= scd_pkg::LFO_IDLE;
      end else begin
         state_ff <= state_in;
         tag_ff   <= state_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scd_pkg::LFO_IDLE:  if (ctrl.refresh) state_in = scd_pkg::LFO_RD_S0;
         scd_pkg::LFO_RD_S0: state_in = scd_pkg::LFO_RD_C0;
         scd_pkg::LFO_RD_C0: state_in = scd_pkg::LFO_RD_S1;
         scd_pkg::LFO_RD_S1: state_in = scd_pkg::LFO_RD_C1;
         scd_pkg::LFO_RD_C1: state_in = scd_pkg::LFO_WAIT;
         scd_pkg::LFO_WAIT:  state_in = scd_pkg::LFO_LOAD;
         scd_pkg::LFO_LOAD:  state_in = scd_pkg::LFO_IDLE;
         default:            state_in = scd_pkg::LFO_IDLE;
      endcase
   end

   // increments truncated toward zero
   assign dsin = $signed({s1_ff[scd_pkg::SAMPLE_W-1], s1_ff})
               - $signed({s0_ff[scd_pkg::SAMPLE_W-1], s0_ff});
   assign dcos = $signed({c1_ff[scd_pkg::SAMPLE_W-1], c1_ff})
               - $signed({c0_ff[scd_pkg::SAMPLE_W-1], c0_ff});
   assign asin = dsin + (dsin[scd_pkg::SAMPLE_W] ?
                 (scd_pkg::SAMPLE_W+1)'(scd_pkg::LFO_CHUNK - 1) : '0);
   assign acos = dcos + (dcos[scd_pkg::SAMPLE_W] ?
                 (scd_pkg::SAMPLE_W+1)'(scd_pkg::LFO_CHUNK - 1) : '0);

   assign nsin = $signed({msin_ff[scd_pkg::SAMPLE_W-1], msin_ff})
               + $signed({isin_ff[scd_pkg::SAMPLE_W-1], isin_ff});
   assign ncos = $signed({mcos_ff[scd_pkg::SAMPLE_W-1], mcos_ff})
               + $signed({icos_ff[scd_pkg::SAMPLE_W-1], icos_ff});

   function automatic scd_pkg::sample_type sat25(logic signed [scd_pkg::SAMPLE_W:0] v);
      scd_pkg::sample_type r;
      if (v[scd_pkg::SAMPLE_W] != v[scd_pkg::SAMPLE_W-1]) begin
         r = v[scd_pkg::SAMPLE_W] ? scd_pkg::S24_MIN : scd_pkg::S24_MAX;
      end else begin
         r = v[scd_pkg::SAMPLE_W-1:0];
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         chunk_ff <= '0;
         msin_ff  <= '0;
         mcos_ff  <= '0;
         isin_ff  <= '0;
         icos_ff  <= '0;
      end else if (state_ff == scd_pkg::LFO_LOAD) begin
         msin_ff  <= s0_ff;
         mcos_ff  <= c0_ff;
         isin_ff  <= scd_pkg::SAMPLE_W'(asin >>> scd_pkg::LFO_CHUNK_BITS);
         icos_ff  <= scd_pkg::SAMPLE_W'(acos >>> scd_pkg::LFO_CHUNK_BITS);
         phase_ff <= end_phase;
      end else if (ctrl.advance) begin
         msin_ff  <= sat25(nsin);
         mcos_ff  <= sat25(ncos);
         chunk_ff <= chunk_ff + 1'b1;
      end
   end

   assign stat.done       = (state_ff == scd_pkg::LFO_LOAD);
   assign stat.chunk_zero = (chunk_ff == '0);
   assign mod_sine        = msin_ff;
   assign mod_cosine      = mcos_ff;

endmodule

`default_nettype wire

### rtl/scd_lane.sv
// ---------------------------------------------------------------------------
// scd_lane
// one side: circular delay line, modulated delay, interpolation and wet mix
// ---------------------------------------------------------------------------
`default_nettype none

module scd_lane (
   input  wire logic                           clock,
   input  wire scd_pkg::lane_ctrl_type         ctrl,
   input  wire scd_pkg::sample_type            sample,
   input  wire scd_pkg::sample_type            acc,
   input  wire scd_pkg::sample_type            mod,
   input  wire logic [scd_pkg::CENTER_W-1:0]   swing,
   input  wire logic [scd_pkg::CENTER_W-1:0]   center,
   input  wire logic [scd_pkg::GAIN_W-1:0]     gain,
   input  wire logic [scd_pkg::LINE_BITS-1:0]  wp,
   input  wire logic                           wrapped,
   output scd_pkg::sample_type                 result
);

   scd_pkg::sample_type line_mem [0:scd_pkg::LINE_DEPTH-1];

   logic signed [44:0]                 prod_ff;
   logic signed [45:0]                 d31;
   logic [30:0]                        d16_raw;
   logic [scd_pkg::POS_W-1:0]          d16_ff, pos;
   logic [scd_pkg::LINE_BITS-1:0]      base_ff, rd_addr;
   logic [scd_pkg::FRAC_W-1:0]         f_ff;
   scd_pkg::sample_type                rd_ff, a_ff, rd_val, interp_ff, result_ff;
   logic                               ok_ff;
   logic signed [41:0]                 pa_ff, pb_ff, gp_ff;
   logic signed [41:0]                 vsum;
   logic signed [24:0]                 wet;
   logic signed [25:0]                 total;

   assign d31 = $signed({3'b0, center, 23'b0}) + $signed({prod_ff[44], prod_ff});
   assign d16_raw = d31[45] ? '0 : d31[45:15];
   assign pos = {wp, {scd_pkg::FRAC_W{1'b0}}} - d16_ff;
   assign rd_addr = ctrl.rd_next ? base_ff + 1'b1 : base_ff;

   always_ff @(posedge clock) begin
      if (ctrl.write) begin
         line_mem[wp] <= sample;
      end
      rd_ff <= line_mem[rd_addr];
      ok_ff <= wrapped || (rd_addr <= wp);
   end

   assign rd_val = ok_ff ? rd_ff : '0;
   assign vsum   = pa_ff + pb_ff;
   assign wet    = gp_ff[40:16];
   assign total  = $signed({{2{acc[scd_pkg::SAMPLE_W-1]}}, acc})
                 + $signed({wet[24], wet});

   always_ff @(posedge clock) begin
      if (ctrl.write) begin
         prod_ff <= $signed({1'b0, swing}) * mod;
      end
      if (ctrl.delay) begin
         if (d16_raw < 31'(scd_pkg::DELAY_MIN)) begin
            d16_ff <= scd_pkg::DELAY_MIN;
         end else if (d16_raw > 31'(scd_pkg::DELAY_MAX)) begin
            d16_ff <= scd_pkg::DELAY_MAX;
         end else begin
            d16_ff <= d16_raw[scd_pkg::POS_W-1:0];
         end
      end
      if (ctrl.pos) begin
         base_ff <= pos[scd_pkg::POS_W-1 -: scd_pkg::LINE_BITS];
         f_ff    <= pos[scd_pkg::FRAC_W-1:0];
      end
      if (ctrl.load_a) begin
         a_ff <= rd_val;
      end
      if (ctrl.mul) begin
         pa_ff <= 42'(a_ff * $signed({1'b0, 17'(18'h10000 - {2'b0, f_ff})}));
         pb_ff <= 42'(rd_val * $signed({1'b0, f_ff}));
      end
      if (ctrl.interp) begin
         interp_ff <= vsum[39:16];
      end
      if (ctrl.gain) begin
         gp_ff <= 42'(interp_ff * $signed({1'b0, gain}));
      end
      if (ctrl.sum) begin
         if (total > 26'sd8388607) begin
            result_ff <= scd_pkg::S24_MAX;
         end else if (total < -26'sd8388608) begin
            result_ff <= scd_pkg::S24_MIN;
         end else begin
            result_ff <= total[scd_pkg::SAMPLE_W-1:0];
         end
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

### rtl/stereo_chorus_delay.sv
// ---------------------------------------------------------------------------
// stereo_chorus_delay
// stereo chorus: two modulated delay lines with a shared sine lfo
// ---------------------------------------------------------------------------
// usage
//   request channel req_*: one stereo frame plus the two accumulator values,
//   taken when req_valid is high and req_stall is low
//   response channel rsp_*: one result per request, held in an output
//   register, taken when rsp_valid is high and rsp_stall is low
//   csr channel: csr_index selects wet_level, center_delay, depth or
//   phase_step, written when csr_valid and csr_ready are high; write only
//   while the block is idle
// timing
//   one request at a time; the first frame of each 32-frame lfo chunk first
//   waits for four sine table reads in the lfo, and a zero wet_level skips
//   the lanes; otherwise the lane sequence of delay, two line reads and four
//   multiplies sets the rate; the next request is taken while a result
//   still waits in the output register; a stalled receiver holds the block
//   at its output step
// reset
//   synchronous; lines read as zero until written, lfo and position cleared,
//   registers back to their defaults; no clearing pass is needed
// ---------------------------------------------------------------------------
`default_nettype none

module stereo_chorus_delay (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic signed [23:0]          req_in_left,
   input  wire logic signed [23:0]          req_in_right,
   input  wire logic signed [23:0]          req_acc_left,
   input  wire logic signed [23:0]          req_acc_right,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [23:0]               rsp_out_left,
   output logic signed [23:0]               rsp_out_right,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [1:0]                  csr_index,
   input  wire logic [31:0]                 csr_wdata
);

`include "stereo_chorus_delay_macros.svh"

   scd_pkg::top_state_type state_ff, state_in;

   logic [scd_pkg::GAIN_W-1:0]    wet_level_ff, depth_ff, gain, dp;
   logic [scd_pkg::CENTER_W-1:0]  center_ff, swing_ff;
   logic [scd_pkg::PHASE_W-1:0]   step_ff;
   logic [36:0]                   swing_prod;

   scd_pkg::sample_type in_l_ff, in_r_ff, acc_l_ff, acc_r_ff;
   scd_pkg::sample_type res_l, res_r, out_l_ff, out_r_ff, mod_s, mod_c;
   logic                bypass_ff;
   logic [scd_pkg::LINE_BITS-1:0] wp_ff;
   logic                wrapped_ff;
   logic                rsp_valid_ff;
   logic                accept, out_load;

   scd_pkg::lfo_ctrl_type  lfo_ctrl;
   scd_pkg::lfo_stat_type  lfo_stat;
   scd_pkg::lane_ctrl_type lane_ctrl;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wet_level_ff <= '0;
         center_ff    <= scd_pkg::CENTER_W'(256);
         depth_ff     <= '0;
         step_ff      <= '0;
      end else if (csr_valid) begin
         unique case (scd_pkg::csr_index_type'(csr_index))
            scd_pkg::CSR_WET_LEVEL:    wet_level_ff <= csr_wdata[scd_pkg::GAIN_W-1:0];
            scd_pkg::CSR_CENTER_DELAY: center_ff    <= csr_wdata[scd_pkg::CENTER_W-1:0];
            scd_pkg::CSR_DEPTH:        depth_ff     <= csr_wdata[scd_pkg::GAIN_W-1:0];
            scd_pkg::CSR_PHASE_STEP:   step_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign gain = (wet_level_ff > scd_pkg::GAIN_ONE) ? scd_pkg::GAIN_ONE : wet_level_ff;
   assign dp   = (depth_ff > scd_pkg::GAIN_ONE) ? scd_pkg::GAIN_ONE : depth_ff;
   assign swing_prod = center_ff * dp;

   always_ff @(posedge clock) begin
      swing_ff <= swing_prod[36:17];
   end

   assign accept   = (state_ff == scd_pkg::ST_IDLE) && req_valid;
   assign out_load = (state_ff == scd_pkg::ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (accept) begin
         in_l_ff   <= req_in_left;
         in_r_ff   <= req_in_right;
         acc_l_ff  <= req_acc_left;
         acc_r_ff  <= req_acc_right;
         bypass_ff <= (wet_level_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      lane_ctrl = '0;
      lfo_ctrl  = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         scd_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (wet_level_ff == '0) begin
                  state_in = scd_pkg::ST_OUT;
               end else if (lfo_stat.chunk_zero) begin
                  lfo_ctrl.refresh = 1'b1;
                  state_in = scd_pkg::ST_LFO;
               end else begin
                  state_in = scd_pkg::ST_WRITE;
               end
            end
         end
         scd_pkg::ST_LFO: begin
            if (lfo_stat.done) begin
               state_in = scd_pkg::ST_WRITE;
            end
         end
         scd_pkg::ST_WRITE: begin
            lane_ctrl.write = 1'b1;
            state_in = scd_pkg::ST_DELAY;
         end
         scd_pkg::ST_DELAY: begin
            lane_ctrl.delay = 1'b1;
            state_in = scd_pkg::ST_POS;
         end
         scd_pkg::ST_POS: begin
            lane_ctrl.pos = 1'b1;
            state_in = scd_pkg::ST_RDA;
         end
         scd_pkg::ST_RDA: begin
            state_in = scd_pkg::ST_RDB;
         end
         scd_pkg::ST_RDB: begin
            lane_ctrl.rd_next = 1'b1;
            lane_ctrl.load_a  = 1'b1;
            state_in = scd_pkg::ST_MUL;
         end
         scd_pkg::ST_MUL: begin
            lane_ctrl.mul = 1'b1;
            state_in = scd_pkg::ST_INTERP;
         end
         scd_pkg::ST_INTERP: begin
            lane_ctrl.interp = 1'b1;
            state_in = scd_pkg::ST_GAIN;
         end
         scd_pkg::ST_GAIN: begin
            lane_ctrl.gain = 1'b1;
            state_in = scd_pkg::ST_SUM;
         end
         scd_pkg::ST_SUM: begin
            lane_ctrl.sum = 1'b1;
            state_in = scd_pkg::ST_OUT;
         end
         scd_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               lfo_ctrl.advance = !bypass_ff;
               state_in = scd_pkg::ST_IDLE;
            end
         end
         default: state_in = scd_pkg::ST_IDLE;
      endcase
   end

   scd_lfo u_lfo (
      .clock      (clock),
      .reset      (reset),
      .phase_step (step_ff),
      .ctrl       (lfo_ctrl),
      .stat       (lfo_stat),
      .mod_sine   (mod_s),
      .mod_cosine (mod_c)
   );

   scd_lane u_lane_left (
      .clock   (clock),
      .ctrl    (lane_ctrl),
      .sample  (in_l_ff),
      .acc     (acc_l_ff),
      .mod     (mod_s),
      .swing   (swing_ff),
      .center  (center_ff),
      .gain    (gain),
      .wp      (wp_ff),
      .wrapped (wrapped_ff),
      .result  (res_l)
   );

   scd_lane u_lane_right (
      .clock   (clock),
      .ctrl    (lane_ctrl),
      .sample  (in_r_ff),
      .acc     (acc_r_ff),
      .mod     (mod_c),
      .swing   (swing_ff),
      .center  (center_ff),
      .gain    (gain),
      .wp      (wp_ff),
      .wrapped (wrapped_ff),
      .result  (res_r)
   );

   // write position and fill state
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
      end else if (out_load && !bypass_ff) begin
         wp_ff <= wp_ff + 1'b1;
         if (wp_ff == scd_pkg::LINE_BITS'(scd_pkg::LINE_DEPTH - 1)) begin
            wrapped_ff <= 1'b1;
         end
      end
   end

   // merge of both lanes, or of the accumulator values in bypass, into the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         out_l_ff <= bypass_ff ? acc_l_ff : res_l;
         out_r_ff <= bypass_ff ? acc_r_ff : res_r;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_left  = out_l_ff;
   assign rsp_out_right = out_r_ff;

   `SCD_ASSERT(a_busy_stalls, (state_ff != scd_pkg::ST_IDLE) |-> req_stall, "busy but not stalled")
   `SCD_ASSERT(a_lfo_done_in_lfo, lfo_stat.done |-> (state_ff == scd_pkg::ST_LFO), "stray lfo done")
   `SCD_ASSERT(a_wp_moves_on_out, $past(reset) || $stable(wp_ff) || $past(out_load && !bypass_ff), "write position moved outside output step")
   `SCD_ASSERT_ALWAYS(a_no_rsp_after_reset, $past(reset) |-> !rsp_valid_ff, "response valid after reset")

endmodule

`default_nettype wire

### bench/stereo_chorus_delay_test.sv
// ---------------------------------------------------------------------------
// stereo_chorus_delay_test
// drives stereo frames through the chorus with random gaps on both sides,
// predicts each output frame from a local copy of the delay lines and lfo,
// and compares every response field by field against that prediction
// ---------------------------------------------------------------------------
`default_nettype none

module stereo_chorus_delay_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [23:0] req_in_left = '0;
   logic signed [23:0] req_in_right = '0;
   logic signed [23:0] req_acc_left = '0;
   logic signed [23:0] req_acc_right = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [23:0] rsp_out_left;
   logic signed [23:0] rsp_out_right;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   stereo_chorus_delay uut (.*);

   typedef struct packed {
      logic signed [23:0] left;
      logic signed [23:0] right;
   } frame_type;

   frame_type chorus_queue[$];
   int error_count = 0;
   int frame_count = 0;
   int response_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   longint cycle_count = 0;

   // predictor state
   int sine_lut[0:1023];
   int left_store[0:scd_pkg::LINE_DEPTH-1];
   int right_store[0:scd_pkg::LINE_DEPTH-1];
   int unsigned wpos;
   bit [31:0] lfo_ph;
   int unsigned chunk_pos;
   int mod_s, mod_c, inc_s, inc_c;
   bit [16:0] wet_reg;
   bit [19:0] center_reg;
   bit [16:0] depth_reg;
   bit [31:0] step_reg;

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int quarter_value(int k);
      longint unsigned x, x2, term, acc;
      x = (longint'(k) * 64'd1686629713) >> 8;
      x2 = (x * x) >> 30;
      term = x;
      acc = x;
      for (int n = 1; n <= 6; n++) begin
         term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
         if (n % 2 == 1) acc = acc - term;
         else acc = acc + term;
      end
      acc = (acc + 64) >> 7;
      if (acc > 64'd8388607) acc = 64'd8388607;
      return int'(acc);
   endfunction

   function automatic int lut_at(bit [31:0] ph);
      return sine_lut[ph[31:22]];
   endfunction

   function automatic longint clamp24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic longint floor_shift(longint v, int sh);
      return v >>> sh;
   endfunction

   function automatic int read_delayed(bit right_side, int unsigned swing, int md);
      longint d31, d16, pos, f, a, b, v;
      int unsigned base, nxt;
      d31 = (longint'(center_reg) << 23) + longint'(swing) * longint'(md);
      if (d31 < 0) d31 = 0;
      d16 = d31 >> 15;
      if (d16 < 65536) d16 = 65536;
      if (d16 > (longint'(scd_pkg::LINE_DEPTH - 2) << 16))
         d16 = longint'(scd_pkg::LINE_DEPTH - 2) << 16;
      pos = (longint'(wpos) << 16) + (longint'(scd_pkg::LINE_DEPTH) << 16) - d16;
      base = int'((pos >> 16) % scd_pkg::LINE_DEPTH);
      nxt = (base + 1) % scd_pkg::LINE_DEPTH;
      f = pos & 64'hFFFF;
      a = right_side ? right_store[base] : left_store[base];
      b = right_side ? right_store[nxt] : left_store[nxt];
      v = a * (65536 - f) + b * f;
      return int'(floor_shift(v, 16));
   endfunction

   function automatic frame_type predict_chorus(int il, int ir, int al, int ar);
      frame_type r;
      longint g, dp, wl, wr;
      int unsigned swing;
      bit [31:0] endp;
      int s1, c1;
      if (wet_reg == 0) begin
         r.left = al[23:0];
         r.right = ar[23:0];
         return r;
      end
      g = wet_reg > 65536 ? 65536 : wet_reg;
      dp = depth_reg > 65536 ? 65536 : depth_reg;
      if (chunk_pos == 0) begin
         endp = lfo_ph + step_reg * 32'd32;
         mod_s = lut_at(lfo_ph);
         mod_c = lut_at(lfo_ph + 32'h4000_0000);
         s1 = lut_at(endp);
         c1 = lut_at(endp + 32'h4000_0000);
         inc_s = (s1 - mod_s) / 32;
         inc_c = (c1 - mod_c) / 32;
         lfo_ph = endp;
      end
      left_store[wpos] = il;
      right_store[wpos] = ir;
      swing = int'((longint'(center_reg) * dp) >> 17);
      wl = floor_shift(longint'(read_delayed(1'b0, swing, mod_s)) * g, 16);
      wr = floor_shift(longint'(read_delayed(1'b1, swing, mod_c)) * g, 16);
      wpos = (wpos + 1) % scd_pkg::LINE_DEPTH;
      mod_s = int'(clamp24(longint'(mod_s) + inc_s));
      mod_c = int'(clamp24(longint'(mod_c) + inc_c));
      chunk_pos = (chunk_pos + 1) % scd_pkg::LFO_CHUNK;
      r.left = 24'(clamp24(longint'(al) + wl));
      r.right = 24'(clamp24(longint'(ar) + wr));
      return r;
   endfunction

   task automatic send_frame(int il, int ir, int al, int ar);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_left <= il[23:0];
      req_in_right <= ir[23:0];
      req_acc_left <= al[23:0];
      req_acc_right <= ar[23:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      chorus_queue.push_back(predict_chorus(il, ir, al, ar));
      frame_count++;
   endtask

   task automatic write_reg(scd_pkg::csr_index_type idx, bit [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         scd_pkg::CSR_WET_LEVEL: wet_reg = value[16:0];
         scd_pkg::CSR_CENTER_DELAY: center_reg = value[19:0];
         scd_pkg::CSR_DEPTH: depth_reg = value[16:0];
         default: step_reg = value;
      endcase
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (chorus_queue.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (30) @(posedge clock);
   endtask

   task automatic setup(int unsigned w, int unsigned c, int unsigned d, bit [31:0] s);
      drain();
      write_reg(scd_pkg::CSR_WET_LEVEL, w);
      write_reg(scd_pkg::CSR_CENTER_DELAY, c);
      write_reg(scd_pkg::CSR_DEPTH, d);
      write_reg(scd_pkg::CSR_PHASE_STEP, s);
      csr_valid <= 1'b0;
   endtask

   function automatic int rand24();
      case ($urandom_range(5))
         0: return 8388607;
         1: return -8388608;
         default: return $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
      endcase
   endfunction

   always @(posedge clock) begin
      frame_type exp_frame;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            response_count++;
            if (chorus_queue.size() == 0) begin
               $error("response with no pending request");
               error_count++;
            end else begin
               exp_frame = chorus_queue.pop_front();
               if (rsp_out_left !== exp_frame.left) begin
                  $error("out_left expected %0d got %0d", exp_frame.left, rsp_out_left);
                  error_count++;
               end
               if (rsp_out_right !== exp_frame.right) begin
                  $error("out_right expected %0d got %0d", exp_frame.right, rsp_out_right);
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic test_bypass();
      send_frame(8388607, -8388608, 8388607, -8388608);
      send_frame(1000, -1000, -8388608, 8388607);
      send_frame(0, 0, 0, 0);
   endtask

   task automatic test_directed();
      setup(65536, 256, 0, 0);
      send_frame(8388607, -8388608, 8388607, -8388608);
      send_frame(-8388608, 8388607, 8388607, -8388608);
      send_frame(8388607, 8388607, 8388607, 8388607);
      send_frame(-8388608, -8388608, -8388608, -8388608);
      // gain above unity, depth above one, extreme step
      setup(131071, 1048575, 131071, 32'hFFFF_FFFF);
      for (int i = 0; i < 6; i++) send_frame(rand24(), rand24(), rand24(), rand24());
      // center delay below one frame, clamped to the one-frame minimum
      setup(1, 0, 65536, 32'h0100_0000);
      for (int i = 0; i < 4; i++) send_frame(rand24(), rand24(), 8388607, -8388608);
      // freeze then resume
      setup(0, 300, 40000, 32'h0080_0000);
      send_frame(5, 6, 7, 8);
      setup(32768, 300, 40000, 32'h0080_0000);
      for (int i = 0; i < 4; i++) send_frame(rand24(), rand24(), rand24(), rand24());
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 130 == 0) begin
            case ($urandom_range(3))
               0: setup($urandom_range(1, 65536), $urandom_range(0, 1048064),
                        $urandom_range(0, 65536), $urandom());
               1: setup($urandom_range(0, 131071), $urandom_range(256, 8000),
                        $urandom_range(0, 131071), $urandom_range(0, 32'h0200_0000));
               2: setup(65536, $urandom_range(0, 1048575), 65536, $urandom());
               default: setup($urandom_range(1, 131071), $urandom_range(256, 200000),
                              $urandom_range(0, 65536), $urandom_range(0, 32'h0040_0000));
            endcase
         end
         send_frame(rand24(), rand24(), rand24(), rand24());
      end
   endtask

   initial begin
      wet_reg = 0; center_reg = 256; depth_reg = 0; step_reg = 0;
      wpos = 0; lfo_ph = 0; chunk_pos = 0;
      mod_s = 0; mod_c = 0; inc_s = 0; inc_c = 0;
      for (int i = 0; i < scd_pkg::LINE_DEPTH; i++) begin
         left_store[i] = 0;
         right_store[i] = 0;
      end
      for (int i = 0; i < 1024; i++) begin
         if ((i / 256) % 2 == 1) sine_lut[i] = quarter_value(256 - i % 256);
         else sine_lut[i] = quarter_value(i % 256);
         if ((i / 256) >= 2) sine_lut[i] = -sine_lut[i];
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_bypass();
      test_directed();
      send_idle_pct = 9; recv_idle_pct = 78;
      test_random(650);
      send_idle_pct = 78; recv_idle_pct = 9;
      test_random(650);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(650);
      drain();
      $display("covered %0d frames, %0d responses checked, over bypass and modulated settings",
               frame_count, response_count);
      if (error_count == 0 && chorus_queue.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
